### hw/rtl/peut_pkg.sv
// peut_pkg: shared types and instruction encodings for the unwind tracker
// used by peut_decode, peut_emit and prologue_epilogue_unwind_tracker
package peut_pkg;

   localparam int OFFSET_BITS_DEF = 20;
   localparam int MAX_RECS        = 3;
   localparam int CNT_BITS        = $clog2(MAX_RECS + 1);

   localparam logic [31:0] MFLR_R0   = 32'h7c0802a6;
   localparam logic [31:0] MTLR_R0   = 32'h7c0803a6;
   localparam logic [31:0] BLR       = 32'h4e800020;
   localparam logic [31:0] MR_MASK   = 32'hffc003ff;
   localparam logic [31:0] MR_R1     = 32'h7d400378;
   localparam logic [15:0] STW_HI    = 16'h9001;
   localparam logic [15:0] STWU_HI   = 16'h9421;
   localparam logic [15:0] LWZ_HI    = 16'h8001;
   localparam logic [15:0] ADDI_HI   = 16'h3821;
   localparam logic [2:0]  CANON_FRM = 3'b101;

   localparam logic KIND_INTERVAL = 1'b0;
   localparam logic KIND_END      = 1'b1;

   typedef struct packed {
      logic        ra_in_frame;
      logic        ra_in_r0;
      logic        sp_saved;
      logic [16:0] frame_bytes;
      logic [15:0] save_disp;
      logic [2:0]  canon_fields;
      logic        canon_taken;
   } track_state_type;

   typedef struct packed {
      logic kind;
      logic ra_in_frame;
      logic ra_in_r0;
      logic sp_saved;
      logic last;
   } rec_flags_type;

endpackage

### hw/rtl/prologue_epilogue_unwind_tracker.sv
// prologue_epilogue_unwind_tracker: top level with input register and tracking state
// depends on peut_pkg, peut_decode and peut_emit
//
// usage: instruction words of a routine arrive in order on the req_ channel,
// routine_start on the first word and routine_last on the final word.
// each word yields zero to three records on the rsp_ channel: an interval at
// routine start, an interval after a recognized prologue or epilogue word,
// and an end marker on the last word; rsp_last_of_run flags the final record
// of a word.
// a taken word waits in the input register, is decoded combinationally and
// is loaded into the result buffer, which shows its first record.
// throughput: one word per cycle while each word gives at most one record and
// rsp_ready stays high; a word with more records holds the result buffer until
// its last record is taken, as the buffer pops one record per cycle on rsp_ready.
// reset clears the tracking state and empties the input register and the
// result buffer. a stalled rsp_ready keeps the current record steady; one
// more word waits in the input register, then req_ready drops.
module prologue_epilogue_unwind_tracker #(
   parameter int OFFSET_BITS = peut_pkg::OFFSET_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [31:0]            req_instr_word,
   input  logic [OFFSET_BITS-1:0] req_word_offset,
   input  logic                   req_routine_start,
   input  logic                   req_routine_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_record_kind,
   output logic [OFFSET_BITS:0]   rsp_start_offset,
   output logic                   rsp_ra_in_frame,
   output logic                   rsp_ra_in_r0,
   output logic                   rsp_sp_saved,
   output logic                   rsp_last_of_run
);
   import peut_pkg::*;

   logic                   in_valid_ff;
   logic [31:0]            word_ff;
   logic [OFFSET_BITS-1:0] offset_ff;
   logic                   start_ff;
   logic                   last_ff;
   track_state_type        state_ff, state_in;
   logic [CNT_BITS-1:0]    rec_cnt;
   rec_flags_type          rec_flags [MAX_RECS];
   logic [OFFSET_BITS:0]   rec_off [MAX_RECS];
   rec_flags_type          out_flags;
   logic                   can_load;
   logic                   advance;

   assign advance   = in_valid_ff && can_load;
   assign req_ready = !in_valid_ff || advance;

   peut_decode #(.OFFSET_BITS(OFFSET_BITS)) u_decode (
      .instr_word    (word_ff),
      .word_offset   (offset_ff),
      .routine_start (start_ff),
      .routine_last  (last_ff),
      .cur_state     (state_ff),
      .nxt_state     (state_in),
      .rec_cnt       (rec_cnt),
      .rec_flags     (rec_flags),
      .rec_off       (rec_off)
   );

   peut_emit #(.OFFSET_BITS(OFFSET_BITS)) u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_cnt   (rec_cnt),
      .load_flags (rec_flags),
      .load_off   (rec_off),
      .can_load   (can_load),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_flags  (out_flags),
      .out_off    (rsp_start_offset)
   );

   assign rsp_record_kind = out_flags.kind;
   assign rsp_ra_in_frame = out_flags.ra_in_frame;
   assign rsp_ra_in_r0    = out_flags.ra_in_r0;
   assign rsp_sp_saved    = out_flags.sp_saved;
   assign rsp_last_of_run = out_flags.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
      if (req_valid && req_ready) begin
         word_ff   <= req_instr_word;
         offset_ff <= req_word_offset;
         start_ff  <= req_routine_start;
         last_ff   <= req_routine_last;
      end
   end

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !can_load) |=> (in_valid_ff && $stable(word_ff)))
      else $error("pending item lost while buffer busy");

   a_state_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      !$past(advance) && !$past(reset) |-> $stable(state_ff))
      else $error("tracking state moved without an item");

   a_canon_values: assert property (@(posedge clock) disable iff (reset)
      state_ff.canon_taken == (state_ff.canon_fields == CANON_FRM))
      else $error("canonical state inconsistent");

endmodule

### hw/rtl/peut_decode.sv
// peut_decode: matches one instruction word against the prologue and epilogue
// patterns, builds the next tracking state and up to three records; uses peut_pkg
module peut_decode #(
   parameter int OFFSET_BITS = peut_pkg::OFFSET_BITS_DEF
) (
   input  logic [31:0]                   instr_word,
   input  logic [OFFSET_BITS-1:0]        word_offset,
   input  logic                          routine_start,
   input  logic                          routine_last,
   input  peut_pkg::track_state_type     cur_state,
   output peut_pkg::track_state_type     nxt_state,
   output logic [peut_pkg::CNT_BITS-1:0] rec_cnt,
   output peut_pkg::rec_flags_type       rec_flags [peut_pkg::MAX_RECS],
   output logic [OFFSET_BITS:0]          rec_off [peut_pkg::MAX_RECS]
);
   import peut_pkg::*;

   logic [15:0]     disp;
   logic [15:0]     hi;
   logic [OFFSET_BITS:0] nxt_off;
   logic [17:0]     fb_plus4;
   track_state_type st;
   logic            hit;

   assign disp     = instr_word[15:0];
   assign hi       = instr_word[31:16];
   assign nxt_off  = {1'b0, word_offset} + {{OFFSET_BITS{1'b0}}, 1'b1};

   always_comb begin
      st  = routine_start ? '0 : cur_state;
      hit = 1'b0;
      fb_plus4 = {st.frame_bytes[16], st.frame_bytes} + 18'd4;
      if (instr_word == MFLR_R0) begin
         st.ra_in_frame = 1'b0;
         st.ra_in_r0    = 1'b1;
         hit            = 1'b1;
      end else if (hi == STW_HI) begin
         st.save_disp = disp;
         if (fb_plus4 == {{2{disp[15]}}, disp} && $signed(disp) > 16'sd4) begin
            st.ra_in_frame = 1'b1;
            st.ra_in_r0    = 1'b0;
            st.sp_saved    = 1'b1;
            if (!st.canon_taken) begin
               st.canon_taken  = 1'b1;
               st.canon_fields = CANON_FRM;
            end
            hit = 1'b1;
         end
      end else if (hi == STWU_HI) begin
         st.ra_in_frame = 1'b0;
         st.sp_saved    = 1'b1;
         st.frame_bytes = 17'd0 - {disp[15], disp};
         hit            = 1'b1;
      end else if (instr_word == MTLR_R0) begin
         st.ra_in_frame = 1'b0;
         st.ra_in_r0    = 1'b0;
         hit            = 1'b1;
      end else if ((instr_word & MR_MASK) == MR_R1 ||
                   (hi == ADDI_HI && {disp[15], disp} == st.frame_bytes)) begin
         st.sp_saved = 1'b0;
         hit         = 1'b1;
      end else if (hi == LWZ_HI && disp == st.save_disp) begin
         st.ra_in_frame = 1'b0;
         st.ra_in_r0    = 1'b1;
         hit            = 1'b1;
      end else if (instr_word == BLR && !routine_last) begin
         if ({st.sp_saved, st.ra_in_r0, st.ra_in_frame} != st.canon_fields) begin
            st.ra_in_frame = st.canon_fields[0];
            st.ra_in_r0    = st.canon_fields[1];
            st.sp_saved    = st.canon_fields[2];
            hit            = 1'b1;
         end
      end
      nxt_state = st;
   end

   // records packed in order: start interval, instruction interval, end marker
   always_comb begin
      logic [CNT_BITS-1:0] n;
      n = '0;
      for (int i = 0; i < MAX_RECS; i++) begin
         rec_flags[i] = '0;
         rec_off[i]   = '0;
      end
      if (routine_start) begin
         rec_flags[n[1:0]] = '{kind: KIND_INTERVAL, default: 1'b0};
         rec_off[n[1:0]]   = {1'b0, word_offset};
         n = n + 1'b1;
      end
      if (hit) begin
         rec_flags[n[1:0]] = '{kind: KIND_INTERVAL, ra_in_frame: st.ra_in_frame,
                               ra_in_r0: st.ra_in_r0, sp_saved: st.sp_saved,
                               last: 1'b0};
         rec_off[n[1:0]]   = nxt_off;
         n = n + 1'b1;
      end
      if (routine_last) begin
         rec_flags[n[1:0]] = '{kind: KIND_END, default: 1'b0};
         rec_off[n[1:0]]   = nxt_off;
         n = n + 1'b1;
      end
      if (n != '0) begin
         rec_flags[n[1:0] - 2'd1].last = 1'b1;
      end
      rec_cnt = n;
   end

endmodule

### hw/rtl/peut_emit.sv
// peut_emit: result buffer holding the records of one item and handing them
// out one per cycle in order while out_ready is high; uses peut_pkg
module peut_emit #(
   parameter int OFFSET_BITS = peut_pkg::OFFSET_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [peut_pkg::CNT_BITS-1:0] load_cnt,
   input  peut_pkg::rec_flags_type       load_flags [peut_pkg::MAX_RECS],
   input  logic [OFFSET_BITS:0]          load_off [peut_pkg::MAX_RECS],
   output logic                          can_load,
   output logic                          out_valid,
   input  logic                          out_ready,
   output peut_pkg::rec_flags_type       out_flags,
   output logic [OFFSET_BITS:0]          out_off
);
   import peut_pkg::*;

   logic [CNT_BITS-1:0] count_ff, count_in;
   rec_flags_type       flags_ff [MAX_RECS];
   rec_flags_type       flags_in [MAX_RECS];
   logic [OFFSET_BITS:0] off_ff [MAX_RECS];
   logic [OFFSET_BITS:0] off_in [MAX_RECS];
   logic                pop;

   assign pop       = (count_ff != '0) && out_ready;
   assign can_load  = (count_ff == '0) || (count_ff == CNT_BITS'(1) && pop);
   assign out_valid = (count_ff != '0);
   assign out_flags = flags_ff[0];
   assign out_off   = off_ff[0];

   always_comb begin
      count_in = count_ff;
      flags_in = flags_ff;
      off_in   = off_ff;
      if (load) begin
         count_in = load_cnt;
         flags_in = load_flags;
         off_in   = load_off;
      end else if (pop) begin
         count_in = count_ff - 1'b1;
         for (int i = 0; i < MAX_RECS - 1; i++) begin
            flags_in[i] = flags_ff[i+1];
            off_in[i]   = off_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      flags_ff <= flags_in;
      off_ff   <= off_in;
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (count_ff == '0 || (count_ff == CNT_BITS'(1) && pop)))
      else $error("record buffer overwritten");

   a_last_on_final: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (flags_ff[0].last == (count_ff == CNT_BITS'(1))))
      else $error("last flag out of place");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !load) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("record count did not drop");

endmodule
